>>> rtl/mwnco_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the NCO.
// Used by mwnco_qrom, multi_waveform_nco and mwnco_checker.
package mwnco_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int QTAB_DEPTH  = 1024;
  localparam int QTAB_LOG2   = $clog2(QTAB_DEPTH);
  localparam int QTAB_AW     = QTAB_LOG2 + 1;
  localparam int SAMPLE_W    = 16;
  localparam int AMP_W       = 15;
  localparam int WAVE_W      = 17;

  // register values are in 2^-32 turn units
  localparam int REG_PH_W    = 32;
  localparam int PH_SHL      = (PHASE_BITS >= REG_PH_W) ? PHASE_BITS - REG_PH_W : 0;
  localparam int PH_SHR      = (PHASE_BITS <  REG_PH_W) ? REG_PH_W - PHASE_BITS : 0;
  // triangle magnitude is rescaled to 17-bit phase units (full scale 32768)
  localparam int TRI_SHL     = (PHASE_BITS < 17) ? 17 - PHASE_BITS : 0;
  localparam int TRI_SHR     = (PHASE_BITS >= 17) ? PHASE_BITS - 17 : 0;

  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // register indexes
  localparam logic [1:0] REG_WAVE_SEL  = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [1:0] REG_PHASE_INC = 2'd2;
  localparam logic [1:0] REG_PHASE_OFF = 2'd3;

  // waveform codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;

  typedef logic [AMP_W-1:0] qrom_t [QTAB_DEPTH+1];

  function automatic logic [PHASE_BITS-1:0] to_phase(input logic [REG_PH_W-1:0] val);
    logic [PHASE_BITS+REG_PH_W-1:0] wide;
    wide = (PHASE_BITS+REG_PH_W)'(val);
    wide = (wide << PH_SHL) >> PH_SHR;
    return wide[PHASE_BITS-1:0];
  endfunction

  // Q30 Taylor series of sin up to x^15, rounded to Q15 and clamped
  function automatic qrom_t build_qrom();
    qrom_t             rom;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    logic [63:0]       v;
    for (int k = 0; k <= QTAB_DEPTH; k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) / QTAB_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          6:       term = term / 156;
          default: term = term / 210;
        endcase
        if ((n & 1) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 64'sd0;
      v = (64'(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      rom[k] = v[AMP_W-1:0];
    end
    return rom;
  endfunction

endpackage

>>> rtl/mwnco_qrom.sv
// Quarter-wave sine table, QTAB_DEPTH+1 entries of unsigned Q15,
// synchronous read with registered output data. Depends on mwnco_pkg.
module mwnco_qrom (
  input  logic                             clk,
  input  logic [mwnco_pkg::QTAB_AW-1:0]    addr,
  output logic [mwnco_pkg::AMP_W-1:0]      rd_data
);

  localparam mwnco_pkg::qrom_t QROM = mwnco_pkg::build_qrom();

  always_ff @(posedge clk) begin
    rd_data <= QROM[addr];
  end

endmodule

>>> rtl/multi_waveform_nco.sv
// Top level of the three-waveform NCO: APB register file, phase accumulator,
// sample pipeline and output FIFO. Depends on mwnco_pkg and mwnco_qrom.
//
// Usage:
//   Each item on the s_ channel is one tick; s_tdata[0] is the restart flag,
//   which zeroes the phase accumulator before that tick's sample. Every item
//   yields exactly one 16-bit signed sample on the m_ channel, in order.
//   Waveform, amplitude, phase increment and phase offset are set over the
//   APB port (byte addresses 0, 4, 8, 12) while no items are in flight.
// Timing:
//   One item per clock while s_tready is high. Each sample passes through the
//   registered steps phase add, sine table read with square/triangle select
//   and amplitude multiply, then the FIFO write; m_tvalid comes up for it as
//   soon as it is in the FIFO.
// Reset (rst, synchronous): accumulator to zero, registers to their defaults
//   (sine, amplitude 32767, increment and offset 0), pipeline and FIFO empty.
// Stall: results wait in an 8-entry output FIFO; s_tready drops only once 8
//   items are accepted but not yet delivered.
module multi_waveform_nco (
  input  logic                              clk,
  input  logic                              rst,
  // stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] restart, [7:1] zero
  // stream out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mwnco_pkg::SAMPLE_W-1:0]    m_tdata,   // [15:0] sample_value
  // APB
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mwnco_pkg::PADDR_W-1:0]     paddr,
  input  logic [mwnco_pkg::PDATA_W-1:0]     pwdata,
  output logic [mwnco_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int PB = mwnco_pkg::PHASE_BITS;

  // registers
  logic [1:0]                       wave_sel;
  logic [mwnco_pkg::AMP_W-1:0]      amplitude;
  logic [mwnco_pkg::REG_PH_W-1:0]   phase_inc;
  logic [mwnco_pkg::REG_PH_W-1:0]   phase_off;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_sel  <= mwnco_pkg::WAVE_SINE;
      amplitude <= mwnco_pkg::AMP_RESET;
      phase_inc <= '0;
      phase_off <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mwnco_pkg::REG_WAVE_SEL:  wave_sel  <= pwdata[1:0];
        mwnco_pkg::REG_AMPLITUDE: amplitude <= pwdata[mwnco_pkg::AMP_W-1:0];
        mwnco_pkg::REG_PHASE_INC: phase_inc <= pwdata;
        mwnco_pkg::REG_PHASE_OFF: phase_off <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mwnco_pkg::REG_WAVE_SEL:  prdata = mwnco_pkg::PDATA_W'(wave_sel);
      mwnco_pkg::REG_AMPLITUDE: prdata = mwnco_pkg::PDATA_W'(amplitude);
      mwnco_pkg::REG_PHASE_INC: prdata = phase_inc;
      mwnco_pkg::REG_PHASE_OFF: prdata = phase_off;
      default:                  prdata = '0;
    endcase
  end

  // accept side and phase accumulator
  logic                    in_acc;
  logic                    out_acc;
  logic [PB-1:0]           acc;
  logic [PB-1:0]           acc_eff;
  logic [mwnco_pkg::FIFO_AW:0] inflight;

  assign s_tready = (inflight != (mwnco_pkg::FIFO_AW+1)'(mwnco_pkg::FIFO_DEPTH));
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;
  assign acc_eff  = s_tdata[0] ? '0 : acc;

  // stage 1: phase
  logic          valid1;
  logic [PB-1:0] p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_acc;
      if (in_acc) begin
        acc <= acc_eff + mwnco_pkg::to_phase(phase_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    p1 <= acc_eff + mwnco_pkg::to_phase(phase_off);
  end

  // stage 2: table read, square and triangle
  logic [mwnco_pkg::QTAB_LOG2-1:0] idx1;
  logic [mwnco_pkg::QTAB_AW-1:0]   rom_addr;
  logic [mwnco_pkg::AMP_W-1:0]     rom_q;
  logic [PB-2:0]                   r1;
  logic [PB-2:0]                   tri_full;
  logic [PB:0]                     tri_wide;
  logic [15:0]                     tri_mag;
  logic signed [mwnco_pkg::WAVE_W-1:0] wave_other;

  assign idx1     = p1[PB-3 -: mwnco_pkg::QTAB_LOG2];
  assign rom_addr = p1[PB-2]
                  ? (mwnco_pkg::QTAB_AW'(mwnco_pkg::QTAB_DEPTH) - {1'b0, idx1})
                  : {1'b0, idx1};

  mwnco_qrom u_qrom (
    .clk     (clk),
    .addr    (rom_addr),
    .rd_data (rom_q)
  );

  assign r1       = {1'b0, p1[PB-3:0]};
  // quadrants 1 and 3 run downward from the quarter turn
  assign tri_full = p1[PB-2] ? ((PB-1)'(1) << (PB-2)) - r1 : r1;
  assign tri_wide = ((PB+1)'(tri_full) << mwnco_pkg::TRI_SHL) >> mwnco_pkg::TRI_SHR;
  assign tri_mag  = tri_wide[15:0];

  always_comb begin
    case (wave_sel)
      mwnco_pkg::WAVE_SQUARE:
        // first half-turn inclusive of the midpoint is positive
        wave_other = (p1 <= (PB'(1) << (PB-1))) ? 17'sd32768 : -17'sd32768;
      mwnco_pkg::WAVE_TRIANGLE:
        wave_other = p1[PB-1] ? -$signed({1'b0, tri_mag}) : $signed({1'b0, tri_mag});
      default:
        wave_other = '0;
    endcase
  end

  logic                                valid2;
  logic                                neg2;
  logic signed [mwnco_pkg::WAVE_W-1:0] wave2;

  always_ff @(posedge clk) begin
    if (rst) valid2 <= 1'b0;
    else valid2 <= valid1;
  end

  always_ff @(posedge clk) begin
    neg2  <= p1[PB-1];
    wave2 <= wave_other;
  end

  // stage 3: amplitude multiply
  logic signed [mwnco_pkg::WAVE_W-1:0] wave3_in;
  logic signed [mwnco_pkg::WAVE_W-1:0] sine_pos;
  logic                                valid3;
  logic signed [32:0]                  prod3;

  assign sine_pos = $signed({2'b00, rom_q});
  assign wave3_in = (wave_sel == mwnco_pkg::WAVE_SINE)
                  ? (neg2 ? -sine_pos : sine_pos) : wave2;

  always_ff @(posedge clk) begin
    if (rst) valid3 <= 1'b0;
    else valid3 <= valid2;
  end

  always_ff @(posedge clk) begin
    prod3 <= wave3_in * $signed({1'b0, amplitude});
  end

  // output FIFO; inflight counts accepted items not yet delivered
  logic [mwnco_pkg::SAMPLE_W-1:0] fifo_mem [mwnco_pkg::FIFO_DEPTH];
  logic [mwnco_pkg::FIFO_AW:0]    wr_ptr;
  logic [mwnco_pkg::FIFO_AW:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (valid3) begin
      fifo_mem[wr_ptr[mwnco_pkg::FIFO_AW-1:0]] <= prod3[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      inflight <= '0;
    end else begin
      if (valid3) wr_ptr <= wr_ptr + 1'b1;
      if (out_acc) rd_ptr <= rd_ptr + 1'b1;
      if (in_acc && !out_acc) inflight <= inflight + 1'b1;
      else if (!in_acc && out_acc) inflight <= inflight - 1'b1;
    end
  end

  assign m_tvalid = (wr_ptr != rd_ptr);
  assign m_tdata  = fifo_mem[rd_ptr[mwnco_pkg::FIFO_AW-1:0]];

endmodule

>>> rtl/mwnco_checker.sv
// Port-level checks for multi_waveform_nco, bound to the top level.
// Depends on mwnco_pkg.
module mwnco_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mwnco_pkg::SAMPLE_W-1:0]  m_tdata
);

  logic [mwnco_pkg::FIFO_AW+1:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if ((s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
      outstanding <= outstanding + 1'b1;
    end else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready)) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != '0)
    else $error("output item without an accepted input item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= (mwnco_pkg::FIFO_AW+2)'(mwnco_pkg::FIFO_DEPTH))
    else $error("more items in flight than the output FIFO holds");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##4 m_tvalid)
    else $error("sample not presented four cycles after its item");

endmodule

bind multi_waveform_nco mwnco_checker u_mwnco_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
